@@ rtl/mau_pkg.sv @@
// Shared types and constants for the modular arithmetic unit.
package mau_pkg;

  localparam int OP_W   = 64;
  localparam int EXP_W  = 63;
  localparam int MOD_W  = 31;
  localparam int MODE_W = 3;
  localparam int CNT_W  = 6;

  localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000003;

  typedef enum logic [MODE_W-1:0] {
    MODE_MUL = 3'd0,
    MODE_ADD = 3'd1,
    MODE_SUB = 3'd2,
    MODE_POW = 3'd3,
    MODE_INV = 3'd4,
    MODE_DIV = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_FIX,
    ST_DISP,
    ST_MUL,
    ST_POW,
    ST_POWB,
    ST_DONE
  } state_t;

endpackage

@@ rtl/modular_arithmetic_unit.sv @@
// Modular arithmetic unit: multiply, add, subtract, power, inverse, divide.
//
// Channels: in_* carries one request per beat (mode in in_tuser, operands
// and exponent in in_tdata); out_* returns one residue per request; cfg_*
// writes the modulus and is always ready, to be used only while idle.
// One shared step unit does a doubling and a conditional add, each reduced
// by the modulus, in every cycle of a reduction or a multiplication. It
// serves both operand reductions (one operand bit a cycle plus a sign fixup)
// and every modular multiplication (one multiplier bit a cycle). Power runs
// up to 63 square-and-multiply rounds through the same step unit. Inverse
// and divide raise to the Fermat exponent, which has at most 31 bits. A
// modulus below two skips the reductions and returns 0.
// One request at a time: in_tready is high only while idle. The result
// waits in an output register; a new request is taken while it waits, and
// a finished result holds until the receiver takes the previous one.
// Reset (rst_n low, synchronous) returns to idle, drops any pending result
// and sets the modulus to 1000003.
module modular_arithmetic_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [30:0]  cfg_data,   // modulus
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // operand_a[63:0], operand_b[127:64], exponent[190:128]
  input  logic [2:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata   // result[30:0]
);

  localparam int OW = mau_pkg::OP_W;
  localparam int EW = mau_pkg::EXP_W;
  localparam int MW = mau_pkg::MOD_W;
  localparam int CW = mau_pkg::CNT_W;

  mau_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [MW-1:0]         mod_r;
  logic [MW-1:0]         acc_r, acc_nxt;
  logic [MW-1:0]         mx_r, mx_nxt;
  logic [MW-1:0]         ra_r, ra_nxt, rb_r, rb_nxt;
  logic [MW-1:0]         res_r, res_nxt, base_r, base_nxt;
  logic [OW-1:0]         sh_r, sh_nxt;
  logic [OW-1:0]         opb_r, opb_nxt;
  logic [EW-1:0]         e_r, e_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [2:0]            mode_r, mode_nxt;
  logic                  sel_b_r, sel_b_nxt;
  logic                  neg_r, neg_nxt, negb_r, negb_nxt;
  logic                  dst_base_r, dst_base_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [MW-1:0]         out_data_r, out_data_nxt;

  logic [MW:0]           mz, t1, t1m, t2, t2m;
  logic [MW-1:0]         addend, step_val;
  logic [MW:0]           sum_ab;
  logic [OW-1:0]         opa_in, opb_in, abs_a, abs_b;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == mau_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  assign opa_in = in_tdata[OW-1:0];
  assign opb_in = in_tdata[2*OW-1:OW];
  assign abs_a  = opa_in[OW-1] ? (~opa_in + 64'd1) : opa_in;
  assign abs_b  = opb_r[OW-1] ? (~opb_r + 64'd1) : opb_r;

  // Shared step: acc = (2*acc + bit*addend) mod m
  assign mz     = {1'b0, mod_r};
  assign addend = (state_r == mau_pkg::ST_RED) ? 31'd1 : mx_r;
  assign t1     = {acc_r, 1'b0};
  assign t1m    = (t1 >= mz) ? (t1 - mz) : t1;
  assign t2     = t1m + (sh_r[OW-1] ? {1'b0, addend} : 32'd0);
  assign t2m    = (t2 >= mz) ? (t2 - mz) : t2;
  assign step_val = t2m[MW-1:0];
  assign sum_ab = {1'b0, ra_r} + {1'b0, rb_r};

  // Hold the modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= mau_pkg::MODULUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mod_r <= cfg_data;
    end
  end

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mau_pkg::ST_IDLE;
      ret_r       <= mau_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    mx_r       <= mx_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    res_r      <= res_nxt;
    base_r     <= base_nxt;
    sh_r       <= sh_nxt;
    opb_r      <= opb_nxt;
    e_r        <= e_nxt;
    cnt_r      <= cnt_nxt;
    mode_r     <= mode_nxt;
    sel_b_r    <= sel_b_nxt;
    neg_r      <= neg_nxt;
    negb_r     <= negb_nxt;
    dst_base_r <= dst_base_nxt;
    out_data_r <= out_data_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    acc_nxt       = acc_r;
    mx_nxt        = mx_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    res_nxt       = res_r;
    base_nxt      = base_r;
    sh_nxt        = sh_r;
    opb_nxt       = opb_r;
    e_nxt         = e_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    sel_b_nxt     = sel_b_r;
    neg_nxt       = neg_r;
    negb_nxt      = negb_r;
    dst_base_nxt  = dst_base_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mau_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_tuser;
          opb_nxt   = opb_in;
          negb_nxt  = opb_in[OW-1];
          e_nxt     = in_tdata[2*OW+EW-1:2*OW];
          if (mod_r < 31'd2) begin
            res_nxt   = '0;
            state_nxt = mau_pkg::ST_DONE;
          end else begin
            sh_nxt    = abs_a;
            neg_nxt   = opa_in[OW-1];
            acc_nxt   = '0;
            cnt_nxt   = CW'(OW - 1);
            sel_b_nxt = 1'b0;
            state_nxt = mau_pkg::ST_RED;
          end
        end
      end
      mau_pkg::ST_RED: begin
        acc_nxt = step_val;
        sh_nxt  = {sh_r[OW-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          state_nxt = mau_pkg::ST_FIX;
        end
      end
      mau_pkg::ST_FIX: begin
        // Fold a negative operand to its non-negative residue
        if (!sel_b_r) begin
          ra_nxt    = (neg_r && acc_r != '0) ? (mod_r - acc_r) : acc_r;
          sh_nxt    = abs_b;
          neg_nxt   = negb_r;
          acc_nxt   = '0;
          cnt_nxt   = CW'(OW - 1);
          sel_b_nxt = 1'b1;
          state_nxt = mau_pkg::ST_RED;
        end else begin
          rb_nxt    = (neg_r && acc_r != '0) ? (mod_r - acc_r) : acc_r;
          state_nxt = mau_pkg::ST_DISP;
        end
      end
      mau_pkg::ST_DISP: begin
        unique case (mode_r)
          mau_pkg::MODE_MUL: begin
            mx_nxt       = ra_r;
            sh_nxt       = {rb_r, {(OW-MW){1'b0}}};
            acc_nxt      = '0;
            cnt_nxt      = CW'(MW - 1);
            dst_base_nxt = 1'b0;
            ret_nxt      = mau_pkg::ST_DONE;
            state_nxt    = mau_pkg::ST_MUL;
          end
          mau_pkg::MODE_ADD: begin
            res_nxt   = (sum_ab >= mz) ? MW'(sum_ab - mz) : sum_ab[MW-1:0];
            state_nxt = mau_pkg::ST_DONE;
          end
          mau_pkg::MODE_SUB: begin
            res_nxt   = (ra_r >= rb_r) ? (ra_r - rb_r) : MW'(sum_ab - {1'b0, rb_r}
                        - {1'b0, rb_r} + mz);
            state_nxt = mau_pkg::ST_DONE;
          end
          mau_pkg::MODE_POW: begin
            base_nxt  = rb_r;
            res_nxt   = 31'd1;
            state_nxt = mau_pkg::ST_POW;
          end
          mau_pkg::MODE_INV: begin
            if (ra_r == '0) begin
              res_nxt   = '0;
              state_nxt = mau_pkg::ST_DONE;
            end else begin
              base_nxt  = ra_r;
              e_nxt     = {{(EW-MW){1'b0}}, mod_r - 31'd2};
              res_nxt   = 31'd1;
              state_nxt = mau_pkg::ST_POW;
            end
          end
          mau_pkg::MODE_DIV: begin
            if (rb_r == '0) begin
              res_nxt   = '0;
              state_nxt = mau_pkg::ST_DONE;
            end else begin
              base_nxt  = rb_r;
              e_nxt     = {{(EW-MW){1'b0}}, mod_r - 31'd2};
              res_nxt   = 31'd1;
              state_nxt = mau_pkg::ST_POW;
            end
          end
          default: begin
            res_nxt   = '0;
            state_nxt = mau_pkg::ST_DONE;
          end
        endcase
      end
      mau_pkg::ST_POW: begin
        // Square-and-multiply round, lowest exponent bit first
        acc_nxt = '0;
        cnt_nxt = CW'(MW - 1);
        if (e_r == '0) begin
          if (mode_r == mau_pkg::MODE_DIV) begin
            mx_nxt       = ra_r;
            sh_nxt       = {res_r, {(OW-MW){1'b0}}};
            dst_base_nxt = 1'b0;
            ret_nxt      = mau_pkg::ST_DONE;
            state_nxt    = mau_pkg::ST_MUL;
          end else begin
            state_nxt = mau_pkg::ST_DONE;
          end
        end else if (e_r[0]) begin
          mx_nxt       = res_r;
          sh_nxt       = {base_r, {(OW-MW){1'b0}}};
          dst_base_nxt = 1'b0;
          ret_nxt      = mau_pkg::ST_POWB;
          state_nxt    = mau_pkg::ST_MUL;
        end else begin
          state_nxt = mau_pkg::ST_POWB;
        end
      end
      mau_pkg::ST_POWB: begin
        mx_nxt       = base_r;
        sh_nxt       = {base_r, {(OW-MW){1'b0}}};
        acc_nxt      = '0;
        cnt_nxt      = CW'(MW - 1);
        e_nxt        = {1'b0, e_r[EW-1:1]};
        dst_base_nxt = 1'b1;
        ret_nxt      = mau_pkg::ST_POW;
        state_nxt    = mau_pkg::ST_MUL;
      end
      mau_pkg::ST_MUL: begin
        acc_nxt = step_val;
        sh_nxt  = {sh_r[OW-2:0], 1'b0};
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          if (dst_base_r) begin
            base_nxt = step_val;
          end else begin
            res_nxt = step_val;
          end
          state_nxt = ret_r;
        end
      end
      mau_pkg::ST_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = mau_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mau_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
